@@ hdl/v4alu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// v4alu_pkg: shared types and constants
// Widths, pipeline stage positions, operation codes and the saturation helper
// for the four-component fixed-point vector unit.
// ----------------------------------------------------------------------------
package v4alu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int VEC_N     = 4;
   localparam int MAT_PAIRS = 8;
   localparam int CSR_IDX_W = 3;
   localparam int PAIR_W    = 2 * WORD_W;

   localparam int PROD_W    = 2 * WORD_W;
   localparam int SUM_W     = PROD_W + 2;

   // square root: one result bit per stage
   localparam int ROOT_W    = WORD_W + 1;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int REM_W     = ROOT_W + 3;

   // normalize divider: quotient never exceeds 1.0
   localparam int DIV_W     = WORD_W + FRAC_BITS;
   localparam int QUOT_W    = FRAC_BITS + 1;

   // stage positions in the main pipeline
   localparam int LANE_STG  = 2;
   localparam int MERGE_STG = LANE_STG + 1;
   localparam int ROOT_STG  = LANE_STG + ROOT_W;
   localparam int LEN_STG   = ROOT_STG + 1;
   localparam int QUOT_STG  = ROOT_STG + QUOT_W;
   localparam int DEPTH     = QUOT_STG + 1;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [VEC_N-1:0] vec_type;

   typedef enum logic [2:0] {
      MODE_ADD   = 3'd0,
      MODE_SUB   = 3'd1,
      MODE_DOT   = 3'd2,
      MODE_LENSQ = 3'd3,
      MODE_LEN   = 3'd4,
      MODE_NORM  = 3'd5,
      MODE_SCALE = 3'd6,
      MODE_XFORM = 3'd7
   } mode_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   typedef struct packed {
      mode_type                      mode;
      vec_type                       r;
      word_type                      scalar;
      logic                          sat;
      logic                          zero;
      logic [VEC_N-1:0][WORD_W-1:0]  mag;
      logic [VEC_N-1:0]              neg;
   } side_type;

   typedef struct packed {
      logic     sat;
      word_type val;
   } sat_type;

   localparam logic signed [SUM_W-1:0] WORD_MAX = (2 ** (WORD_W - 1)) - 1;
   localparam logic signed [SUM_W-1:0] WORD_MIN = -WORD_MAX - 1;

   function automatic sat_type sat_word(input logic signed [SUM_W-1:0] v);
      sat_type s;
      s.sat = 1'b0;
      s.val = v[WORD_W-1:0];
      if (v > WORD_MAX) begin
         s.sat = 1'b1;
         s.val = WORD_MAX[WORD_W-1:0];
      end else if (v < WORD_MIN) begin
         s.sat = 1'b1;
         s.val = WORD_MIN[WORD_W-1:0];
      end
      return s;
   endfunction

endpackage
`default_nettype wire

@@ hdl/v4alu_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// v4alu_lane: four-product dot lane
// Four signed products, then a two-level registered adder tree, exact sum.
// ----------------------------------------------------------------------------
module v4alu_lane import v4alu_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  vec_type                 a,
   input  vec_type                 y,
   output logic signed [SUM_W-1:0] sum
);

   logic signed [PROD_W-1:0] prod_ff [VEC_N];
   logic signed [PROD_W:0]   pair_ff [2];
   logic signed [SUM_W-1:0]  sum_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < VEC_N; i++) begin
            prod_ff[i] <= $signed(a[i]) * $signed(y[i]);
         end
         pair_ff[0] <= prod_ff[0] + prod_ff[1];
         pair_ff[1] <= prod_ff[2] + prod_ff[3];
         sum_ff     <= pair_ff[0] + pair_ff[1];
      end
   end

   assign sum = sum_ff;

endmodule
`default_nettype wire

@@ hdl/v4alu_sqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// v4alu_sqrt: pipelined floor square root
// Restoring method, one root bit per stage, ROOT_W stages.
// ----------------------------------------------------------------------------
module v4alu_sqrt import v4alu_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  rad,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic [RAD_W-1:0]  rad_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [REM_W:0]    diff;

      if (s == 0) begin : g_first
         assign rad_cur  = rad;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign rad_cur  = rad_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
      end

      assign rem_sh = {rem_cur[REM_W-3:0], rad_cur[RAD_W-1 -: 2]};
      assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_cur, 2'b01};
      assign diff   = {1'b0, rem_sh} - {1'b0, trial};

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= {rad_cur[RAD_W-3:0], 2'b00};
            rem_ff[s]  <= diff[REM_W] ? rem_sh : diff[REM_W-1:0];
            root_ff[s] <= {root_cur[ROOT_W-2:0], ~diff[REM_W]};
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule
`default_nettype wire

@@ hdl/v4alu_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// v4alu_div: pipelined unsigned divider lane
// Restoring division, one quotient bit per stage, quotient below 2^QUOT_W.
// ----------------------------------------------------------------------------
module v4alu_div import v4alu_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [ROOT_W-1:0] divisor,
   output logic [QUOT_W-1:0] quot
);

   logic [DIV_W-1:0]  rem_ff [QUOT_W];
   logic [ROOT_W-1:0] dvs_ff [QUOT_W];
   logic [QUOT_W-1:0] q_ff   [QUOT_W];

   for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
      logic [DIV_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] dvs_cur;
      logic [QUOT_W-1:0] q_cur;
      logic [DIV_W+1:0]  dsh;
      logic [DIV_W+1:0]  diff;

      if (s == 0) begin : g_first
         assign rem_cur = dividend;
         assign dvs_cur = divisor;
         assign q_cur   = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[s-1];
         assign dvs_cur = dvs_ff[s-1];
         assign q_cur   = q_ff[s-1];
      end

      assign dsh  = {{(DIV_W+2-ROOT_W){1'b0}}, dvs_cur} << (QUOT_W - 1 - s);
      assign diff = {2'b00, rem_cur} - dsh;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= diff[DIV_W+1] ? rem_cur : diff[DIV_W-1:0];
            dvs_ff[s] <= dvs_cur;
            q_ff[s]   <= {q_cur[QUOT_W-2:0], ~diff[DIV_W+1]};
         end
      end
   end

   assign quot = q_ff[QUOT_W-1];

endmodule
`default_nettype wire

@@ hdl/vec4_vector_alu_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vec4_vector_alu_top: Q16.16 four-component vector unit
// Add, subtract, dot, squared length, length, normalize, scale and 4x4
// matrix transform on signed fixed-point vectors.
// ----------------------------------------------------------------------------
// One request per cycle, every mode, unless req_stall holds the input. All
// modes share one pipeline: multiply and adder tree, square root (one root
// bit per stage) and divide (one quotient bit per stage), then the output
// register. Four lanes of four 32x32 multipliers each run side by side;
// lane j forms column j of a transform or component j of a scale, lane 0
// alone serves dot and length. A stall on the result side freezes the whole
// pipeline, and stalls the input, only while a finished result is held.
// Matrix pairs are written through the csr port (always ready) and must
// only change while the unit is empty. Status: 0 ok, 1 saturated,
// 2 normalize of a zero vector (all outputs zero).
// ----------------------------------------------------------------------------
module vec4_vector_alu_top import v4alu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_mode,
   input  logic [WORD_W-1:0]    req_a_x,
   input  logic [WORD_W-1:0]    req_a_y,
   input  logic [WORD_W-1:0]    req_a_z,
   input  logic [WORD_W-1:0]    req_a_w,
   input  logic [WORD_W-1:0]    req_b_x,
   input  logic [WORD_W-1:0]    req_b_y,
   input  logic [WORD_W-1:0]    req_b_z,
   input  logic [WORD_W-1:0]    req_b_w,
   input  logic [WORD_W-1:0]    req_scale_factor,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_W-1:0]    rsp_r_x,
   output logic [WORD_W-1:0]    rsp_r_y,
   output logic [WORD_W-1:0]    rsp_r_z,
   output logic [WORD_W-1:0]    rsp_r_w,
   output logic [WORD_W-1:0]    rsp_scalar_out,
   output logic [1:0]           rsp_status,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PAIR_W-1:0]    csr_data
);

   // ---------------------------------------------------------------------
   // pipeline control: one global advance, bubbles flow with valid bits
   // ---------------------------------------------------------------------
   logic                en;
   logic [DEPTH-1:0]    vld_ff;
   logic                rsp_valid_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // matrix registers
   // ---------------------------------------------------------------------
   logic [PAIR_W-1:0] mat_ff [MAT_PAIRS];
   word_type          mtx    [VEC_N*VEC_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAT_PAIRS; k++) begin
            mat_ff[k] <= '0;
         end
      end else if (csr_valid) begin
         mat_ff[csr_index] <= csr_data;
      end
   end

   for (genvar k = 0; k < VEC_N*VEC_N; k++) begin : g_mtx
      assign mtx[k] = mat_ff[k/2][(k%2)*WORD_W +: WORD_W];
   end

   // ---------------------------------------------------------------------
   // request decode
   // ---------------------------------------------------------------------
   mode_type mode_req;
   vec_type  a_req;
   vec_type  b_req;

   assign mode_req = mode_type'(req_mode);
   assign a_req    = {req_a_w, req_a_z, req_a_y, req_a_x};
   assign b_req    = {req_b_w, req_b_z, req_b_y, req_b_x};

   // lane operands: lane j, element i
   vec_type lane_y [VEC_N];

   for (genvar j = 0; j < VEC_N; j++) begin : g_opnd
      for (genvar i = 0; i < VEC_N; i++) begin : g_elem
         always_comb begin
            case (mode_req)
               MODE_DOT:   lane_y[j][i] = (j == 0) ? b_req[i] : '0;
               MODE_LENSQ,
               MODE_LEN,
               MODE_NORM:  lane_y[j][i] = (j == 0) ? a_req[i] : '0;
               MODE_SCALE: lane_y[j][i] = (i == j) ? req_scale_factor : '0;
               MODE_XFORM: lane_y[j][i] = mtx[VEC_N*i + j];
               default:    lane_y[j][i] = '0;
            endcase
         end
      end
   end

   // stage 0 sideband: add/sub done here, magnitudes for normalize
   side_type side0;

   always_comb begin
      logic signed [SUM_W-1:0] t;
      sat_type                 st;
      side0        = '0;
      side0.mode   = mode_req;
      for (int i = 0; i < VEC_N; i++) begin
         side0.neg[i] = a_req[i][WORD_W-1];
         side0.mag[i] = a_req[i][WORD_W-1] ? (WORD_W'(0) - a_req[i]) : a_req[i];
         if (mode_req == MODE_SUB) begin
            t = $signed(a_req[i]) - $signed(b_req[i]);
         end else begin
            t = $signed(a_req[i]) + $signed(b_req[i]);
         end
         st = sat_word(t);
         if (mode_req == MODE_ADD || mode_req == MODE_SUB) begin
            side0.r[i] = st.val;
            side0.sat  = side0.sat | st.sat;
         end
      end
   end

   // ---------------------------------------------------------------------
   // dot lanes
   // ---------------------------------------------------------------------
   logic signed [SUM_W-1:0] lane_sum [VEC_N];

   for (genvar j = 0; j < VEC_N; j++) begin : g_lane
      v4alu_lane u_lane (
         .clock (clock),
         .en    (en),
         .a     (a_req),
         .y     (lane_y[j]),
         .sum   (lane_sum[j])
      );
   end

   // merge: truncate, saturate and place the lane results
   side_type side_ff [DEPTH];
   side_type side_in [DEPTH];
   side_type side_m;

   always_comb begin
      logic signed [SUM_W-1:0] sh;
      sat_type                 st;
      side_m = side_ff[LANE_STG];
      for (int j = 0; j < VEC_N; j++) begin
         sh = lane_sum[j] >>> FRAC_BITS;
         st = sat_word(sh);
         if (side_m.mode == MODE_SCALE || side_m.mode == MODE_XFORM) begin
            side_m.r[j] = st.val;
            side_m.sat  = side_m.sat | st.sat;
         end
         if (j == 0 && (side_m.mode == MODE_DOT || side_m.mode == MODE_LENSQ)) begin
            side_m.scalar = st.val;
            side_m.sat    = side_m.sat | st.sat;
         end
      end
   end

   // ---------------------------------------------------------------------
   // length: floor sqrt of the exact sum of squares from lane 0
   // ---------------------------------------------------------------------
   logic [ROOT_W-1:0] root;
   side_type          side_l;

   v4alu_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (RAD_W'(unsigned'(lane_sum[0]))),
      .root  (root)
   );

   // roots of 2^31 and above do not fit the signed word
   always_comb begin
      side_l = side_ff[ROOT_STG];
      if (side_l.mode == MODE_LEN) begin
         if (root[ROOT_W-1:WORD_W-1] != '0) begin
            side_l.scalar = WORD_MAX[WORD_W-1:0];
            side_l.sat    = 1'b1;
         end else begin
            side_l.scalar = root[WORD_W-1:0];
         end
      end
      if (side_l.mode == MODE_NORM) begin
         side_l.zero = (root == '0);
      end
   end

   // ---------------------------------------------------------------------
   // normalize: one divider lane per component
   // ---------------------------------------------------------------------
   logic [QUOT_W-1:0] quot [VEC_N];

   for (genvar i = 0; i < VEC_N; i++) begin : g_div
      v4alu_div u_div (
         .clock    (clock),
         .en       (en),
         .dividend ({side_ff[ROOT_STG].mag[i], {FRAC_BITS{1'b0}}}),
         .divisor  (root),
         .quot     (quot[i])
      );
   end

   // ---------------------------------------------------------------------
   // sideband pipeline
   // ---------------------------------------------------------------------
   for (genvar k = 0; k < DEPTH; k++) begin : g_side
      if (k == 0) begin : g_s0
         assign side_in[k] = side0;
      end else if (k == MERGE_STG) begin : g_sm
         assign side_in[k] = side_m;
      end else if (k == LEN_STG) begin : g_sl
         assign side_in[k] = side_l;
      end else begin : g_sp
         assign side_in[k] = side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DEPTH; k++) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[DEPTH-2:0], req_valid};
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   // ---------------------------------------------------------------------
   // final select and output register
   // ---------------------------------------------------------------------
   side_type   fin;
   logic [1:0] status_in;
   side_type   out_ff;
   logic [1:0] status_ff;

   always_comb begin
      word_type qx;
      fin = side_ff[QUOT_STG];
      for (int i = 0; i < VEC_N; i++) begin
         qx = WORD_W'(quot[i]);
         if (fin.mode == MODE_NORM) begin
            if (fin.zero) begin
               fin.r[i] = '0;
            end else begin
               fin.r[i] = fin.neg[i] ? (WORD_W'(0) - qx) : qx;
            end
         end
      end
      if (fin.mode == MODE_NORM && fin.zero) begin
         status_in = ST_ZERO;
      end else if (fin.sat) begin
         status_in = ST_SAT;
      end else begin
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff    <= fin;
         status_ff <= status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_r_x        = out_ff.r[0];
   assign rsp_r_y        = out_ff.r[1];
   assign rsp_r_z        = out_ff.r[2];
   assign rsp_r_w        = out_ff.r[3];
   assign rsp_scalar_out = out_ff.scalar;
   assign rsp_status     = status_ff;

endmodule
`default_nettype wire
